// ----- hw/rtl/wrp_pkg.sv -----
// Shared constants, types and the sine/cosine tables of the wireframe geometry unit.
package wrp_pkg;

	// Angle resolution and trig precision
	localparam int ANGLE_STEPS    = 128;
	localparam int ANGLE_BITS     = $clog2(ANGLE_STEPS);
	localparam int TRIG_FRAC_BITS = 14;
	localparam int TRIG_W         = TRIG_FRAC_BITS + 2;

	// Datapath widths
	localparam int IN_W   = 16;
	localparam int OUT_W  = 16;
	localparam int C_W    = 20;
	localparam int SUM_W  = C_W + TRIG_W + 2;
	localparam int PROD_W = C_W + IN_W;
	localparam int NUM_W  = PROD_W + 10;
	localparam int DEN_W  = 30;
	localparam int QBITS  = OUT_W + 1;
	localparam int REM_W  = ((NUM_W > DEN_W + QBITS) ? NUM_W : DEN_W + QBITS) + 1;
	localparam int DIV_LAT = QBITS + 3;

	// Projection constants
	localparam int EYE_OFFSET = 'h95;
	localparam int EYE_SCALE  = 'h90;
	localparam int FLAT_DIV   = 'h100;
	localparam int UNIT_STEP  = 256;

	localparam logic signed [OUT_W-1:0] OUT_MAX  = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] OUT_MIN  = -16'sh8000;
	localparam logic signed [OUT_W-1:0] UNIT_POS = 16'sd256;
	localparam logic signed [OUT_W-1:0] UNIT_NEG = -16'sd256;

	localparam longint unsigned PI_Q30 = (64'd314159265 << 30) / 64'd100000000;

	typedef enum logic [1:0] {
		CMD_PERSP = 2'd0,
		CMD_FLAT  = 2'd1,
		CMD_LINE  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_e;

	typedef logic signed [C_W-1:0]    coord_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef trig_t trig_tab_t [ANGLE_STEPS];

	// One divider lane's operands, with an override value that bypasses the quotient
	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
		logic                    frc;
		logic signed [OUT_W-1:0] val;
	} lane_in_t;

	// Line set-up, ready for both lanes
	typedef struct packed {
		lane_in_t           lx;
		lane_in_t           ly;
		logic [OUT_W-1:0]   cnt;
	} line_t;

	// Divide a series term by the factorial step of term n
	function automatic longint unsigned series_div(input longint unsigned t, input bit odd,
			input int n);
		case (n)
			1:       return odd ? t / 64'd6   : t / 64'd2;
			2:       return odd ? t / 64'd20  : t / 64'd12;
			3:       return odd ? t / 64'd42  : t / 64'd30;
			4:       return odd ? t / 64'd72  : t / 64'd56;
			5:       return odd ? t / 64'd110 : t / 64'd90;
			6:       return odd ? t / 64'd156 : t / 64'd132;
			7:       return odd ? t / 64'd210 : t / 64'd182;
			8:       return odd ? t / 64'd272 : t / 64'd240;
			9:       return odd ? t / 64'd342 : t / 64'd306;
			default: return odd ? t / 64'd420 : t / 64'd380;
		endcase
	endfunction

	// Taylor series in Q30, eleven terms
	function automatic longint series(input longint unsigned a, input bit odd);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x2   = (a * a) >> 30;
		term = odd ? a : (64'd1 << 30);
		sum  = longint'(term);
		for (int n = 1; n <= 10; n++) begin
			term = series_div((term * x2) >> 30, odd, n);
			if (n % 2 == 1) sum = sum - longint'(term);
			else            sum = sum + longint'(term);
		end
		return sum;
	endfunction

	// Round Q30 to the nearest trig-format value, clamping negatives to zero
	function automatic trig_t to_trig(input longint v);
		if (v < 0) return '0;
		return TRIG_W'((64'(v) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
	endfunction

	// Build a full-turn sine or cosine table from the first quadrant
	function automatic trig_tab_t build_tab(input bit want_cos);
		trig_tab_t       t;
		longint unsigned a;
		int              q;
		int              r;
		trig_t           s;
		trig_t           c;
		for (int k = 0; k < ANGLE_STEPS; k++) begin
			q = (4 * k) / ANGLE_STEPS;
			r = (4 * k) % ANGLE_STEPS;
			a = (PI_Q30 / 2) * 64'(r) / ANGLE_STEPS;
			s = to_trig(series(a, 1'b1));
			c = to_trig(series(a, 1'b0));
			case (q % 4)
				0:       t[k] = want_cos ? c : s;
				1:       t[k] = want_cos ? -s : c;
				2:       t[k] = want_cos ? -c : -s;
				default: t[k] = want_cos ? s : -c;
			endcase
		end
		return t;
	endfunction

	localparam trig_tab_t SIN_TAB = build_tab(1'b0);
	localparam trig_tab_t COS_TAB = build_tab(1'b1);

endpackage

// ----- hw/rtl/wrp_rot_stage.sv -----
// One plane rotation with rounding to integer, registered.
module wrp_rot_stage import wrp_pkg::*; (
	input  logic   clk,
	input  logic   adv,
	input  coord_t a,
	input  coord_t b,
	input  trig_t  s,
	input  trig_t  c,
	output coord_t a_rot,
	output coord_t b_rot
);

	localparam logic signed [SUM_W-1:0] BIAS = SUM_W'(1) <<< (TRIG_FRAC_BITS - 1);

	logic signed [SUM_W-1:0] sum_a, sum_b, rnd_a, rnd_b;
	coord_t ra_s1, rb_s1;

	// a' = a*c - b*s, b' = a*s + b*c, rounded half up
	always_comb begin
		sum_a = SUM_W'(a) * SUM_W'(c) - SUM_W'(b) * SUM_W'(s);
		sum_b = SUM_W'(a) * SUM_W'(s) + SUM_W'(b) * SUM_W'(c);
		rnd_a = (sum_a + BIAS) >>> TRIG_FRAC_BITS;
		rnd_b = (sum_b + BIAS) >>> TRIG_FRAC_BITS;
	end

	// Hold on stall
	always_ff @(posedge clk) begin
		if (adv) begin
			ra_s1 <= rnd_a[C_W-1:0];
			rb_s1 <= rnd_b[C_W-1:0];
		end
	end

	assign a_rot = ra_s1;
	assign b_rot = rb_s1;

endmodule

// ----- hw/rtl/wrp_div_lane.sv -----
// Pipelined restoring divider lane: truncating signed quotient, saturated to 16 bits.
module wrp_div_lane import wrp_pkg::*; (
	input  logic                    clk,
	input  logic                    adv,
	input  lane_in_t                din,
	output logic signed [OUT_W-1:0] res
);

	logic [NUM_W-1:0]        nm_s1;
	logic [DEN_W-1:0]        dm_s1;
	logic                    neg_s1, frc_s1;
	logic signed [OUT_W-1:0] val_s1;

	logic [REM_W-1:0]        rem_s [QBITS+1];
	logic [DEN_W-1:0]        dm_s  [QBITS+1];
	logic [QBITS-1:0]        q_s   [QBITS+1];
	logic                    ovf_s [QBITS+1];
	logic                    neg_s [QBITS+1];
	logic                    frc_s [QBITS+1];
	logic signed [OUT_W-1:0] val_s [QBITS+1];

	logic signed [OUT_W-1:0] res_s, res_d;
	logic [QBITS-1:0]        mag;

	// Split into sign and magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= din.num[NUM_W-1] ^ din.den[DEN_W-1];
			nm_s1  <= din.num[NUM_W-1] ? NUM_W'(-din.num) : NUM_W'(din.num);
			dm_s1  <= din.den[DEN_W-1] ? DEN_W'(-din.den) : DEN_W'(din.den);
			frc_s1 <= din.frc;
			val_s1 <= din.val;
		end
	end

	// Flag quotients too large for the bit stages, then one quotient bit per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= REM_W'(nm_s1);
			dm_s[0]  <= dm_s1;
			q_s[0]   <= '0;
			ovf_s[0] <= REM_W'(nm_s1) >= (REM_W'(dm_s1) << QBITS);
			neg_s[0] <= neg_s1;
			frc_s[0] <= frc_s1;
			val_s[0] <= val_s1;
			for (int j = 1; j <= QBITS; j++) begin
				if (rem_s[j-1] >= (REM_W'(dm_s[j-1]) << (QBITS - j))) begin
					rem_s[j] <= rem_s[j-1] - (REM_W'(dm_s[j-1]) << (QBITS - j));
					q_s[j]   <= q_s[j-1] | (QBITS'(1) << (QBITS - j));
				end else begin
					rem_s[j] <= rem_s[j-1];
					q_s[j]   <= q_s[j-1];
				end
				dm_s[j]  <= dm_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				neg_s[j] <= neg_s[j-1];
				frc_s[j] <= frc_s[j-1];
				val_s[j] <= val_s[j-1];
			end
		end
	end

	// Apply sign, saturate, or take the override
	always_comb begin
		mag = q_s[QBITS];
		if (frc_s[QBITS]) begin
			res_d = val_s[QBITS];
		end else if (neg_s[QBITS]) begin
			if (ovf_s[QBITS] || mag > QBITS'(32768)) res_d = OUT_MIN;
			else res_d = OUT_W'(QBITS'(0) - mag);
		end else begin
			if (ovf_s[QBITS] || mag > QBITS'(32767)) res_d = OUT_MAX;
			else res_d = OUT_W'(mag);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s <= res_d;
		end
	end

	assign res = res_s;

endmodule

// ----- hw/rtl/wireframe_rotate_project.sv -----
// Top level of the wireframe geometry unit: rotation, projection and line set-up.
// One beat is accepted every clock cycle while out_stall is low; each beat passes
// through six stages of decode, three rotations and projection products, then
// twenty stages of the two divider lanes, which resolve one quotient bit per stage.
// cmd 0 rotates about X, Y, Z and divides by the perspective depth, cmd 1 rotates
// and scales by scale/256, cmd 2 returns the line steps and step count, any other
// cmd returns zeros. A zero perspective divisor gives zeros with div_error set.
// Stall stops the whole pipeline.
module wireframe_rotate_project import wrp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              cmd,
	input  logic signed [IN_W-1:0]  px,
	input  logic signed [IN_W-1:0]  py,
	input  logic signed [IN_W-1:0]  pz,
	input  logic signed [IN_W-1:0]  rot_x,
	input  logic signed [IN_W-1:0]  rot_y,
	input  logic signed [IN_W-1:0]  rot_z,
	input  logic signed [IN_W-1:0]  scale,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] out_x,
	output logic signed [OUT_W-1:0] out_y,
	output logic [OUT_W-1:0]        out_count,
	output logic                    div_error
);

	logic adv;

	// Decode
	logic [IN_W-1:0]       nrx, nry, nrz;
	logic signed [IN_W-1:0] dx, dy;
	logic [IN_W:0]         ax, ay;
	coord_t                z_in;
	line_t                 line_d;

	cmd_e   cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	coord_t x_s1, y_s1, z_s1, x_s2, y_s3, z_s4;
	logic signed [IN_W-1:0] sc_s1, sc_s2, sc_s3, sc_s4;
	trig_t  sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	trig_t  sy_s2, cy_s2, sz_s2, cz_s2, sz_s3, cz_s3;
	line_t  line_s1, line_s2, line_s3, line_s4, line_s5;
	logic   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	coord_t y2, z2, z3, x3, xf, yf;

	logic signed [PROD_W-1:0] px_s5, py_s5;
	logic signed [DEN_W-1:0]  dz_s5;

	lane_in_t         lx_d, ly_d, lx_s6, ly_s6;
	logic             err_d, err_s6;
	logic [OUT_W-1:0] cnt_d, cnt_s6;

	logic             vd_s   [DIV_LAT];
	logic             err_ds [DIV_LAT];
	logic [OUT_W-1:0] cnt_ds [DIV_LAT];

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Angle indices and line deltas
	always_comb begin
		nrx = IN_W'(-rot_x);
		nry = IN_W'(-rot_y);
		nrz = IN_W'(-rot_z);
		z_in = (cmd_e'(cmd) == CMD_PERSP) ? C_W'(pz) - C_W'(EYE_OFFSET) : C_W'(pz);
		dx = IN_W'(rot_x - px);
		dy = IN_W'(rot_y - py);
		ax = dx[IN_W-1] ? (IN_W+1)'(0) - (IN_W+1)'(dx) : (IN_W+1)'(dx);
		ay = dy[IN_W-1] ? (IN_W+1)'(0) - (IN_W+1)'(dy) : (IN_W+1)'(dy);
		line_d.lx.num = NUM_W'(dx) * NUM_W'(UNIT_STEP);
		line_d.ly.num = NUM_W'(dy) * NUM_W'(UNIT_STEP);
		line_d.lx.den = DEN_W'(ay);
		line_d.ly.den = DEN_W'(ax);
		if (ax > ay) begin
			line_d.cnt    = OUT_W'(ax + 1'b1);
			line_d.lx.frc = 1'b1;
			line_d.lx.val = dx[IN_W-1] ? UNIT_NEG : UNIT_POS;
			line_d.ly.frc = 1'b0;
			line_d.ly.val = '0;
		end else if (dy != '0) begin
			line_d.cnt    = OUT_W'(ay + 1'b1);
			line_d.lx.frc = 1'b0;
			line_d.lx.val = '0;
			line_d.ly.frc = 1'b1;
			line_d.ly.val = dy[IN_W-1] ? UNIT_NEG : UNIT_POS;
		end else begin
			line_d.cnt    = '0;
			line_d.lx.frc = 1'b1;
			line_d.lx.val = '0;
			line_d.ly.frc = 1'b1;
			line_d.ly.val = '0;
		end
	end

	// Stage 1: latch the beat and look up the trig values
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= cmd_e'(cmd);
			x_s1    <= C_W'(px);
			y_s1    <= C_W'(py);
			z_s1    <= z_in;
			sc_s1   <= scale;
			sx_s1   <= SIN_TAB[nrx[ANGLE_BITS-1:0]];
			cx_s1   <= COS_TAB[nrx[ANGLE_BITS-1:0]];
			sy_s1   <= SIN_TAB[nry[ANGLE_BITS-1:0]];
			cy_s1   <= COS_TAB[nry[ANGLE_BITS-1:0]];
			sz_s1   <= SIN_TAB[nrz[ANGLE_BITS-1:0]];
			cz_s1   <= COS_TAB[nrz[ANGLE_BITS-1:0]];
			line_s1 <= line_d;
		end
	end

	// Stages 2 to 4: rotate about X, then Y, then Z
	wrp_rot_stage u_rot_x (
		.clk(clk), .adv(adv), .a(y_s1), .b(z_s1), .s(sx_s1), .c(cx_s1),
		.a_rot(y2), .b_rot(z2)
	);

	wrp_rot_stage u_rot_y (
		.clk(clk), .adv(adv), .a(z2), .b(x_s2), .s(sy_s2), .c(cy_s2),
		.a_rot(z3), .b_rot(x3)
	);

	wrp_rot_stage u_rot_z (
		.clk(clk), .adv(adv), .a(x3), .b(y_s3), .s(sz_s3), .c(cz_s3),
		.a_rot(xf), .b_rot(yf)
	);

	// Carry the side data alongside the rotations
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2  <= cmd_s1;
			x_s2    <= x_s1;
			sc_s2   <= sc_s1;
			sy_s2   <= sy_s1;
			cy_s2   <= cy_s1;
			sz_s2   <= sz_s1;
			cz_s2   <= cz_s1;
			line_s2 <= line_s1;
			cmd_s3  <= cmd_s2;
			y_s3    <= y2;
			sc_s3   <= sc_s2;
			sz_s3   <= sz_s2;
			cz_s3   <= cz_s2;
			line_s3 <= line_s2;
			cmd_s4  <= cmd_s3;
			z_s4    <= z3;
			sc_s4   <= sc_s3;
			line_s4 <= line_s3;
		end
	end

	// Stage 5: scale products and perspective depth
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s5  <= cmd_s4;
			px_s5   <= PROD_W'(xf) * PROD_W'(sc_s4);
			py_s5   <= PROD_W'(yf) * PROD_W'(sc_s4);
			dz_s5   <= (DEN_W'(z_s4) + DEN_W'(EYE_OFFSET)) * DEN_W'(EYE_SCALE);
			line_s5 <= line_s4;
		end
	end

	// Stage 6: pick the divider operands for the command
	always_comb begin
		lx_d  = '0;
		ly_d  = '0;
		err_d = 1'b0;
		cnt_d = '0;
		case (cmd_s5)
			CMD_PERSP: begin
				lx_d.num = NUM_W'(px_s5) * NUM_W'(EYE_OFFSET);
				ly_d.num = NUM_W'(py_s5) * NUM_W'(EYE_OFFSET);
				lx_d.den = dz_s5;
				ly_d.den = dz_s5;
				lx_d.frc = (dz_s5 == '0);
				ly_d.frc = (dz_s5 == '0);
				err_d    = (dz_s5 == '0);
			end
			CMD_FLAT: begin
				lx_d.num = NUM_W'(px_s5);
				ly_d.num = NUM_W'(py_s5);
				lx_d.den = DEN_W'(FLAT_DIV);
				ly_d.den = DEN_W'(FLAT_DIV);
			end
			CMD_LINE: begin
				lx_d  = line_s5.lx;
				ly_d  = line_s5.ly;
				cnt_d = line_s5.cnt;
			end
			default: begin
				lx_d.frc = 1'b1;
				ly_d.frc = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lx_s6  <= lx_d;
			ly_s6  <= ly_d;
			err_s6 <= err_d;
			cnt_s6 <= cnt_d;
		end
	end

	// Divider lanes
	wrp_div_lane u_div_x (.clk(clk), .adv(adv), .din(lx_s6), .res(out_x));
	wrp_div_lane u_div_y (.clk(clk), .adv(adv), .din(ly_s6), .res(out_y));

	// Delay count and error to match the lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			err_ds[0] <= err_s6;
			cnt_ds[0] <= cnt_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				err_ds[i] <= err_ds[i-1];
				cnt_ds[i] <= cnt_ds[i-1];
			end
		end
	end

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) vd_s[i] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			vd_s[0] <= v_s6;
			for (int i = 1; i < DIV_LAT; i++) vd_s[i] <= vd_s[i-1];
		end
	end

	assign out_valid = vd_s[DIV_LAT-1];
	assign out_count = cnt_ds[DIV_LAT-1];
	assign div_error = err_ds[DIV_LAT-1];

endmodule

// ----- tb/tb.sv -----
// Regression testbench for the wireframe geometry unit, with its own rotation and projection predictor.
`timescale 1ns / 1ps

module tb import wrp_pkg::*; ();

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        cnt;
		logic               err;
	} geo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic signed [15:0] px = '0, py = '0, pz = '0;
	logic signed [15:0] rot_x = '0, rot_y = '0, rot_z = '0, scale = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] out_x, out_y;
	logic [15:0] out_count;
	logic div_error;

	geo_result_t pending_results[$];
	longint sine_q14[ANGLE_STEPS];
	longint cosine_q14[ANGLE_STEPS];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;

	localparam int QUIET_LIMIT = 5000;

	wireframe_rotate_project u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .px(px), .py(py), .pz(pz),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .scale(scale),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_count(out_count), .div_error(div_error)
	);

	always #10 clk = ~clk;

	// Eleven-term Q30 Taylor series for sine (odd) or cosine
	function automatic longint taylor_q30(longint unsigned a, bit odd);
		longint unsigned sq, term, d;
		longint acc;
		sq = (a * a) >> 30;
		term = odd ? a : (64'd1 << 30);
		acc = longint'(term);
		for (int n = 1; n <= 10; n++) begin
			d = odd ? 64'(2 * n) * 64'(2 * n + 1) : 64'(2 * n - 1) * 64'(2 * n);
			term = ((term * sq) >> 30) / d;
			if (n % 2 == 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		return acc;
	endfunction

	function automatic longint q30_to_q14(longint v);
		if (v < 0) return 0;
		return longint'((64'(v) + (64'd1 << 15)) >> 16);
	endfunction

	// Fill the trig tables from the first quadrant
	task automatic fill_trig_tables();
		longint unsigned ang;
		longint unsigned pi_q30;
		longint s, c;
		int q, r;
		pi_q30 = (64'd314159265 << 30) / 64'd100000000;
		for (int k = 0; k < ANGLE_STEPS; k++) begin
			q = (4 * k) / ANGLE_STEPS;
			r = (4 * k) % ANGLE_STEPS;
			ang = (pi_q30 / 2) * 64'(r) / ANGLE_STEPS;
			s = q30_to_q14(taylor_q30(ang, 1'b1));
			c = q30_to_q14(taylor_q30(ang, 1'b0));
			case (q)
				0: begin sine_q14[k] = s; cosine_q14[k] = c; end
				1: begin sine_q14[k] = c; cosine_q14[k] = -s; end
				2: begin sine_q14[k] = -s; cosine_q14[k] = -c; end
				default: begin sine_q14[k] = -c; cosine_q14[k] = s; end
			endcase
		end
	endtask

	// Round Q14 to integer, ties toward +infinity
	function automatic longint round_q14(longint v);
		return (v + (64'sd1 <<< 13)) >>> 14;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int turn_index(logic signed [15:0] a);
		int neg;
		neg = -int'(a);
		return neg & (ANGLE_STEPS - 1);
	endfunction

	function automatic geo_result_t predict_geometry(logic [1:0] op,
			logic signed [15:0] ax, ay, az, ra, rb, rc, sc);
		geo_result_t res;
		longint x, y, z, y2, z2, x2, s, c, den, dx, dy, mx, my;
		logic signed [15:0] d16;
		res = '{x: '0, y: '0, cnt: '0, err: 1'b0};
		if (op == CMD_PERSP || op == CMD_FLAT) begin
			x = ax; y = ay; z = az;
			if (op == CMD_PERSP) z -= EYE_OFFSET;
			s = sine_q14[turn_index(ra)]; c = cosine_q14[turn_index(ra)];
			y2 = round_q14(y * c - z * s);
			z2 = round_q14(y * s + z * c);
			s = sine_q14[turn_index(rb)]; c = cosine_q14[turn_index(rb)];
			x2 = round_q14(x * c + z2 * s);
			z = round_q14(-x * s + z2 * c);
			s = sine_q14[turn_index(rc)]; c = cosine_q14[turn_index(rc)];
			x = round_q14(x2 * c - y2 * s);
			y = round_q14(x2 * s + y2 * c);
			if (op == CMD_PERSP) begin
				den = EYE_SCALE * (z + EYE_OFFSET);
				if (den == 0) res.err = 1'b1;
				else begin
					res.x = 16'(clamp16(x * sc * EYE_OFFSET / den));
					res.y = 16'(clamp16(y * sc * EYE_OFFSET / den));
				end
			end else begin
				res.x = 16'(clamp16(x * sc / FLAT_DIV));
				res.y = 16'(clamp16(y * sc / FLAT_DIV));
			end
		end else if (op == CMD_LINE) begin
			d16 = ra - ax; dx = d16;
			d16 = rb - ay; dy = d16;
			mx = dx < 0 ? -dx : dx;
			my = dy < 0 ? -dy : dy;
			if (mx > my) begin
				res.cnt = 16'(mx + 1);
				res.y = 16'(clamp16(dy * UNIT_STEP / mx));
				res.x = dx < 0 ? UNIT_NEG : UNIT_POS;
			end else if (dy != 0) begin
				res.cnt = 16'(my + 1);
				res.x = 16'(clamp16(dx * UNIT_STEP / my));
				res.y = dy < 0 ? UNIT_NEG : UNIT_POS;
			end
		end
		return res;
	endfunction

	// Offer one beat, with random idle cycles ahead, and hold it until accepted
	task automatic send_item(logic [1:0] op, logic signed [15:0] ax, ay, az, ra, rb, rc, sc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op; px <= ax; py <= ay; pz <= az;
		rot_x <= ra; rot_y <= rb; rot_z <= rc; scale <= sc;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_geometry(op, ax, ay, az, ra, rb, rc, sc));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return $urandom_range(1, 0) ? 16'sh7fff : -16'sh8000;
			default: return 16'($urandom_range(2000)) - 16'sd1000;
		endcase
	endfunction

	function automatic logic signed [15:0] rand_angle();
		return $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(255)) - 16'sd128;
	endfunction

	// Receiver: random hold-off, or a long counted hold when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin
		geo_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d cnt=%0d err=%0b",
					$time, out_x, out_y, out_count, div_error);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_x !== want.x || out_y !== want.y || out_count !== want.cnt
						|| div_error !== want.err) begin
					$display("%0t: mismatch expected x=%0d y=%0d cnt=%0d err=%0b, got x=%0d y=%0d cnt=%0d err=%0b",
						$time, want.x, want.y, want.cnt, want.err,
						out_x, out_y, out_count, div_error);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("wireframe_rotate_project regression: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic test_extremes();
		send_item(CMD_PERSP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256);
		send_item(CMD_PERSP, 16'sd100, -16'sd50, 16'sd20, 16'sd16, 16'sd32, 16'sd5, 16'sd256);
		send_item(CMD_PERSP, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff,
			-16'sh8000, 16'sh7fff);
		send_item(CMD_PERSP, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000,
			16'sh7fff, -16'sh8000);
		send_item(CMD_FLAT, 16'sd300, 16'sd200, -16'sd100, 16'sd10, 16'sd64, 16'sd127, 16'sd512);
		send_item(CMD_FLAT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff);
		send_item(CMD_FLAT, -16'sh8000, -16'sh8000, -16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff);
		send_item(CMD_FLAT, 16'sd1, 16'sd1, 16'sd1, 16'sd32, 16'sd96, -16'sd1, -16'sh8000);
		send_item(CMD_LINE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_item(CMD_LINE, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd3, 16'sd0, 16'sd0);
		send_item(CMD_LINE, 16'sd0, 16'sd0, 16'sd0, -16'sd3, -16'sd10, 16'sd0, 16'sd0);
		send_item(CMD_LINE, 16'sd5, 16'sd5, 16'sd0, -16'sd5, -16'sd5, 16'sd0, 16'sd0);
		send_item(CMD_LINE, -16'sh8000, -16'sh8000, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0);
		send_item(CMD_LINE, 16'sd0, 16'sd0, 16'sd0, -16'sh8000, 16'sd1, 16'sd0, 16'sd0);
		send_item(CMD_LINE, 16'sh7fff, 16'sd0, 16'sd0, -16'sh7fff, 16'sd0, 16'sd0, 16'sd0);
		send_item(CMD_NONE, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7);
		send_item(CMD_NONE, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
		drain_results();
	endtask

	task automatic test_random(int count, int s_pct, int r_pct);
		int pick;
		logic [1:0] op;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			op = pick < 45 ? CMD_PERSP : pick < 75 ? CMD_FLAT : pick < 97 ? CMD_LINE : CMD_NONE;
			send_item(op, rand_coord(), rand_coord(), rand_coord(),
				op == CMD_LINE ? rand_coord() : rand_angle(),
				op == CMD_LINE ? rand_coord() : rand_angle(),
				rand_angle(), 16'($urandom));
		end
		drain_results();
	endtask

	// Hold the receiver off while the sender keeps offering beats
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 300;
		for (int i = 0; i < 80; i++)
			send_item(CMD_FLAT, rand_coord(), rand_coord(), rand_coord(),
				rand_angle(), rand_angle(), rand_angle(), 16'($urandom));
		drain_results();
	endtask

	initial begin
		fill_trig_tables();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random(200, 19, 62);
		test_random(200, 62, 19);
		test_random(200, 0, 0);
		test_backpressure();
		if (error_count == 0)
			$display("wireframe_rotate_project regression: pass");
		else
			$display("wireframe_rotate_project regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/wrp_pkg.sv
hw/rtl/wrp_rot_stage.sv
hw/rtl/wrp_div_lane.sv
hw/rtl/wireframe_rotate_project.sv
tb/tb.sv
